/* hw/rtl/acpu_pkg.sv */
package acpu_pkg;

  // Default data memory depth in bytes
  localparam int unsigned MEM_DEPTH_DEFAULT = 256;

  // Machine word and stream widths
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned REQ_W       = 4;
  localparam int unsigned S_TDATA_W   = 24;  // 4 + 8 + 8 bits, zero-padded to 3 bytes
  localparam int unsigned OUT_FIELD_W = 19;  // 8 + 1 + 1 + 8 + 1 bits
  localparam int unsigned M_TDATA_W   = 24;

  // Decoupling queue between decode and execute
  localparam int unsigned QUEUE_DEPTH = 2;

  // Accumulator sign bit
  localparam logic [DATA_W-1:0] SIGN_MASK = 8'h80;

  // Request type codes on the input stream
  localparam logic [REQ_W-1:0] REQ_PRELOAD = 4'd0;
  localparam logic [REQ_W-1:0] REQ_NOP     = 4'd1;
  localparam logic [REQ_W-1:0] REQ_HLT     = 4'd2;
  localparam logic [REQ_W-1:0] REQ_NOT     = 4'd3;
  localparam logic [REQ_W-1:0] REQ_STA     = 4'd4;
  localparam logic [REQ_W-1:0] REQ_LDA     = 4'd5;
  localparam logic [REQ_W-1:0] REQ_ADD     = 4'd6;
  localparam logic [REQ_W-1:0] REQ_OR      = 4'd7;
  localparam logic [REQ_W-1:0] REQ_AND     = 4'd8;
  localparam logic [REQ_W-1:0] REQ_JMP     = 4'd9;
  localparam logic [REQ_W-1:0] REQ_JN      = 4'd10;
  localparam logic [REQ_W-1:0] REQ_JZ      = 4'd11;
  localparam logic [REQ_W-1:0] REQ_JNZ     = 4'd12;

  // Decoded operation carried through the queue
  typedef enum logic [3:0] {
    OP_PRELOAD,
    OP_NOP,
    OP_HLT,
    OP_NOT,
    OP_STA,
    OP_LDA,
    OP_ADD,
    OP_OR,
    OP_AND,
    OP_JMP,
    OP_JN,
    OP_JZ,
    OP_JNZ,
    OP_IGNORE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [1:0]        pc_step;  // counter advance when no jump is taken
    logic [DATA_W-1:0] addr;     // full operand, used as jump target
    logic [DATA_W-1:0] value;    // preload byte
  } instr_t;

endpackage

/* hw/rtl/acpu_front.sv */
module acpu_front import acpu_pkg::*; #(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(MEM_DEPTH)
) (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // req_type [3:0], operand_address [11:4], preload_value [19:12]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 q_full_i,
  output logic                 push_o,
  output instr_t               instr_o,
  output logic [AW-1:0]        idx_o
);

  logic [REQ_W-1:0]  req_type;
  logic [DATA_W-1:0] operand_address;
  logic [DATA_W-1:0] preload_value;
  logic [AW-1:0]     idx_lut [256];

  assign req_type        = s_axis_tdata[3:0];
  assign operand_address = s_axis_tdata[11:4];
  assign preload_value   = s_axis_tdata[19:12];

  // Address folding into the memory, worked out at elaboration
  for (genvar a = 0; a < 256; a++) begin : g_idx
    assign idx_lut[a] = AW'(a % MEM_DEPTH);
  end

  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;
  assign idx_o         = idx_lut[operand_address];

  always_comb begin
    instr_o.addr    = operand_address;
    instr_o.value   = preload_value;
    instr_o.op      = OP_IGNORE;
    instr_o.pc_step = 2'd0;
    case (req_type)
      REQ_PRELOAD: instr_o.op = OP_PRELOAD;
      REQ_NOP: begin
        instr_o.op      = OP_NOP;
        instr_o.pc_step = 2'd1;
      end
      REQ_HLT: instr_o.op = OP_HLT;
      REQ_NOT: begin
        instr_o.op      = OP_NOT;
        instr_o.pc_step = 2'd1;
      end
      REQ_STA: begin
        instr_o.op      = OP_STA;
        instr_o.pc_step = 2'd2;
      end
      REQ_LDA: begin
        instr_o.op      = OP_LDA;
        instr_o.pc_step = 2'd2;
      end
      REQ_ADD: begin
        instr_o.op      = OP_ADD;
        instr_o.pc_step = 2'd2;
      end
      REQ_OR: begin
        instr_o.op      = OP_OR;
        instr_o.pc_step = 2'd2;
      end
      REQ_AND: begin
        instr_o.op      = OP_AND;
        instr_o.pc_step = 2'd2;
      end
      REQ_JMP: begin
        instr_o.op      = OP_JMP;
        instr_o.pc_step = 2'd2;
      end
      REQ_JN: begin
        instr_o.op      = OP_JN;
        instr_o.pc_step = 2'd2;
      end
      REQ_JZ: begin
        instr_o.op      = OP_JZ;
        instr_o.pc_step = 2'd2;
      end
      REQ_JNZ: begin
        instr_o.op      = OP_JNZ;
        instr_o.pc_step = 2'd2;
      end
      default: instr_o.op = OP_IGNORE;
    endcase
  end

endmodule

/* hw/rtl/acpu_queue.sv */
module acpu_queue import acpu_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hw/rtl/acpu_back.sv */
module acpu_back import acpu_pkg::*; #(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(MEM_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  instr_t               instr_i,
  input  logic [AW-1:0]        idx_i,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // accumulator [7:0], negative_flag [8], zero_flag [9],
  // program_counter [17:10], halted [18]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  // Data memory with per-byte valid bits; an unwritten byte reads as zero
  logic [DATA_W-1:0]    mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mem_vld_q;
  logic [DATA_W-1:0]    rd_data_q;
  logic                 rd_vld_q;
  logic                 fwd_hit_q, fwd_hit_d;
  logic [DATA_W-1:0]    fwd_data_q;

  // Execute stage
  logic          ex_valid_q, ex_valid_d;
  instr_t        ex_instr_q;
  logic [AW-1:0] ex_idx_q;
  logic          ex_fire, load;

  // Architectural state
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] pc_q, pc_d;
  logic              halt_q, halt_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_acc_q, out_pc_q;
  logic              out_neg_q, out_zero_q, out_halt_q;

  logic [DATA_W-1:0] operand;
  logic              taken;
  logic              wr_en;
  logic [DATA_W-1:0] wr_data;

  assign ex_fire = ex_valid_q && (!out_valid_q || m_axis_tready);
  assign load    = q_valid_i && (!ex_valid_q || ex_fire);
  assign q_pop_o = load;

  // The byte written by the item ahead is newer than the registered read
  assign operand = fwd_hit_q ? fwd_data_q : (rd_vld_q ? rd_data_q : '0);

  always_comb begin
    acc_d   = acc_q;
    pc_d    = pc_q;
    halt_d  = halt_q;
    taken   = 1'b0;
    wr_en   = 1'b0;
    wr_data = acc_q;
    if (ex_instr_q.op == OP_PRELOAD) begin
      wr_en   = 1'b1;
      wr_data = ex_instr_q.value;
    end else if (!halt_q) begin
      case (ex_instr_q.op)
        OP_HLT: halt_d = 1'b1;
        OP_NOT: acc_d = ~acc_q;
        OP_STA: wr_en = 1'b1;
        OP_LDA: acc_d = operand;
        OP_ADD: acc_d = acc_q + operand;
        OP_OR:  acc_d = acc_q | operand;
        OP_AND: acc_d = acc_q & operand;
        OP_JMP: taken = 1'b1;
        OP_JN:  taken = ((acc_q & SIGN_MASK) != '0);
        OP_JZ:  taken = (acc_q == '0);
        OP_JNZ: taken = (acc_q != '0);
        default: ;
      endcase
      pc_d = taken ? ex_instr_q.addr : pc_q + DATA_W'(ex_instr_q.pc_step);
    end
  end

  always_comb begin
    ex_valid_d = ex_valid_q;
    fwd_hit_d  = fwd_hit_q;
    if (load) begin
      ex_valid_d = 1'b1;
      fwd_hit_d  = ex_fire && wr_en && (ex_idx_q == idx_i);
    end else if (ex_fire) begin
      ex_valid_d = 1'b0;
      fwd_hit_d  = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ex_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      mem_vld_q   <= '0;
      acc_q       <= '0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ex_valid_q  <= ex_valid_d;
      fwd_hit_q   <= fwd_hit_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        rd_vld_q <= mem_vld_q[idx_i];
      end
      if (ex_fire) begin
        acc_q  <= acc_d;
        pc_q   <= pc_d;
        halt_q <= halt_d;
        if (wr_en) begin
          mem_vld_q[ex_idx_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire && wr_en) begin
      mem_q[ex_idx_q] <= wr_data;
    end
    if (load) begin
      rd_data_q  <= mem_q[idx_i];
      fwd_data_q <= wr_data;
      ex_instr_q <= instr_i;
      ex_idx_q   <= idx_i;
    end
    if (ex_fire) begin
      out_acc_q  <= acc_d;
      out_pc_q   <= pc_d;
      out_halt_q <= halt_d;
      out_neg_q  <= ((acc_d & SIGN_MASK) != '0);
      out_zero_q <= (acc_d == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - OUT_FIELD_W){1'b0}}, out_halt_q, out_pc_q,
                          out_zero_q, out_neg_q, out_acc_q};

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt mark cleared without reset");

  a_halt_freezes_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_fire && halt_q) |=> (acc_q == $past(acc_q) && pc_q == $past(pc_q)))
    else $error("state changed after halt");

  a_fwd_with_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> ex_valid_q)
    else $error("forwarded byte without an item in execute");

  a_out_from_execute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ex_valid_q))
    else $error("result appeared without an executed item");

endmodule

/* hw/rtl/accumulator_cpu_execute_unit.sv */
// Execute unit of an 8-bit accumulator machine with a byte-wide data memory.
// Input stream (s_axis_*): one transaction per preload or decoded instruction;
// tdata carries the request type, the operand address and the preload byte.
// Output stream (m_axis_*): exactly one transaction per input transaction, in
// order, carrying the accumulator, its negative and zero flags, the program
// counter and the halt mark as they stand after that item.
// Structure: a decode front classifies each transaction and folds its address
// into the memory, a two-entry queue decouples it from the execute back, which
// reads memory into its execute register, then executes and fills the output register.
// Throughput: one transaction per cycle while m_axis_tready stays high; the limit
// is the single execute stage owning the accumulator and the memory write port.
// A result goes through the queue and execute register to the output register.
// A store followed at once by a read of the same byte is forwarded, so no
// bubbles appear on read-after-write.
// Reset: accumulator, counter and halt mark clear, and every memory byte reads
// as zero until written (per-byte valid bits cleared at once, no sweep).
// Output stall: the result holds in the output register, execute and the queue
// fill up, then s_axis_tready drops; nothing is lost or repeated.
module accumulator_cpu_execute_unit import acpu_pkg::*; #(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // req_type [3:0], operand_address [11:4], preload_value [19:12]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // accumulator [7:0], negative_flag [8], zero_flag [9],
  // program_counter [17:10], halted [18]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AW      = $clog2(MEM_DEPTH);
  localparam int unsigned ENTRY_W = $bits(instr_t) + AW;

  logic               q_full;
  logic               q_push;
  logic               q_valid;
  logic               q_pop;
  instr_t             fe_instr;
  logic [AW-1:0]      fe_idx;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;
  instr_t             be_instr;
  logic [AW-1:0]      be_idx;

  // Decode front
  acpu_front #(
    .MEM_DEPTH(MEM_DEPTH)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .instr_o      (fe_instr),
    .idx_o        (fe_idx)
  );

  assign q_wdata = {fe_idx, fe_instr};

  // Decoupling queue
  acpu_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_rdata)
  );

  assign be_idx   = q_rdata[ENTRY_W-1 -: AW];
  assign be_instr = instr_t'(q_rdata[$bits(instr_t)-1:0]);

  // Execute back: memory, accumulator, counter, halt mark, output register
  acpu_back #(
    .MEM_DEPTH(MEM_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .instr_i      (be_instr),
    .idx_i        (be_idx),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule
